// ===== design/sgi_pkg.sv =====
// ============================================================================
// sgi_pkg
// Shared constants and types for the segment intersection unit.
// ============================================================================
package sgi_pkg;

   // Default coordinate width
   localparam int COORD_BITS_DEF = 16;

   // Result classification
   typedef enum logic [1:0] {
      OUT_NONE    = 2'd0,
      OUT_POINT   = 2'd1,
      OUT_SEGMENT = 2'd2
   } outcome_type;

endpackage

// ===== design/sgi_div.sv =====
// ============================================================================
// sgi_div
// Pipelined restoring divider: signed numerator over signed determinant,
// quotient truncated toward zero and saturated well beyond the coordinate
// range. One prep stage, one stage per quotient bit, one saturate stage.
// ============================================================================
module sgi_div import sgi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic [COORD_BITS+4:0]         adv,
   input  logic signed [3*COORD_BITS+2:0] num,
   input  logic signed [2*COORD_BITS+2:0] den,
   output logic signed [COORD_BITS+3:0]  quo
);

   localparam int CW   = COORD_BITS;
   localparam int NW   = 3*CW+3;
   localparam int RW   = 2*CW+3;
   localparam int QW   = CW+3;
   localparam int QSW  = CW+4;
   localparam logic [QW-1:0] LIM = QW'(1) << (CW+2);

   logic [RW-1:0] rem_ff [0:QW];
   logic [RW-1:0] ud_ff  [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic          neg_ff [0:QW];
   logic          ovf_ff [0:QW];
   logic signed [QSW-1:0] quo_ff;

   logic [NW-1:0] mag_n;
   logic [RW-1:0] mag_d;
   logic [RW-1:0] hi_n;

   // Prep: magnitudes, sign, overflow of the high part
   always_comb begin
      mag_n = num[NW-1] ? NW'(~num + 1'b1) : NW'(num);
      mag_d = den[RW-1] ? RW'(~den + 1'b1) : RW'(den);
      hi_n  = RW'(mag_n[NW-1:QW]);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         rem_ff[0] <= hi_n;
         ud_ff[0]  <= mag_d;
         low_ff[0] <= mag_n[QW-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= num[NW-1] ^ den[RW-1];
         ovf_ff[0] <= (hi_n >= mag_d);
      end
   end

   // One quotient bit per stage
   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [RW-1:0] trial;
      logic          take;
      always_comb begin
         trial = {rem_ff[j-1][RW-2:0], low_ff[j-1][QW-1]};
         take  = (trial >= ud_ff[j-1]);
      end
      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j] <= take ? RW'(trial - ud_ff[j-1]) : trial;
            ud_ff[j]  <= ud_ff[j-1];
            low_ff[j] <= {low_ff[j-1][QW-2:0], 1'b0};
            q_ff[j]   <= {q_ff[j-1][QW-2:0], take};
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   // Saturate and apply sign
   logic [QW-1:0]         sat_mag;
   logic signed [QSW-1:0] sat_q;
   always_comb begin
      sat_mag = (ovf_ff[QW] || (q_ff[QW] > LIM)) ? LIM : q_ff[QW];
      sat_q   = neg_ff[QW] ? -$signed(QSW'(sat_mag)) : $signed(QSW'(sat_mag));
   end

   always_ff @(posedge clock) begin
      if (adv[QW+1]) begin
         quo_ff <= sat_q;
      end
   end

   assign quo = quo_ff;

endmodule

// ===== design/segment_intersection_unit.sv =====
// ============================================================================
// segment_intersection_unit
// Classifies how two integer line segments meet and reports the crossing.
// ============================================================================
// The unit takes one segment pair per cycle while the output is not stalled and
// returns one result per pair; most of the pipeline depth is set by the divider,
// which resolves one quotient bit per stage for COORD_BITS+3 stages. Each stage
// holds its item while the stage after it is full and stalled, so bubbles close
// up and input keeps flowing until every stage holds a result.
module segment_intersection_unit import sgi_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_a_start_x,
   input  logic signed [COORD_BITS-1:0] req_a_start_y,
   input  logic signed [COORD_BITS-1:0] req_a_end_x,
   input  logic signed [COORD_BITS-1:0] req_a_end_y,
   input  logic signed [COORD_BITS-1:0] req_b_start_x,
   input  logic signed [COORD_BITS-1:0] req_b_start_y,
   input  logic signed [COORD_BITS-1:0] req_b_end_x,
   input  logic signed [COORD_BITS-1:0] req_b_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_outcome,
   output logic signed [COORD_BITS-1:0] rsp_cross_x,
   output logic signed [COORD_BITS-1:0] rsp_cross_y
);

   localparam int CW     = COORD_BITS;
   localparam int DW     = CW+1;
   localparam int PW     = 2*CW;
   localparam int CCW    = 2*CW+1;
   localparam int DPW    = 2*CW+2;
   localparam int DETW   = 2*CW+3;
   localparam int NW     = 3*CW+3;
   localparam int QW     = CW+3;
   localparam int QSW    = CW+4;
   localparam int OW     = CW+5;
   localparam int XPW    = DW+OW;
   localparam int KDIV   = 5;
   localparam int KQ     = QW+7;
   localparam int KL     = QW+8;
   localparam int STAGES = QW+9;

   typedef logic signed [CW-1:0] crd_type;
   typedef crd_type crd_set_type [0:7];

   // ---------------------------------------------------------------------
   // Stage control
   // ---------------------------------------------------------------------
   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;

   // Load a stage when it is empty or its successor moves on
   always_comb begin
      en[STAGES] = !rsp_stall;
      for (int k = STAGES-1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   assign req_stall = !en[0];

   // ---------------------------------------------------------------------
   // Sidecar: coordinates and flags travel with the item
   // ---------------------------------------------------------------------
   crd_set_type crd_in;
   crd_set_type crd_ff [0:KQ-1];
   logic        par_ff [1:KQ];
   logic        dz_ff  [2:KQ];

   always_comb begin
      crd_in[0] = req_a_start_x;
      crd_in[1] = req_a_start_y;
      crd_in[2] = req_a_end_x;
      crd_in[3] = req_a_end_y;
      crd_in[4] = req_b_start_x;
      crd_in[5] = req_b_start_y;
      crd_in[6] = req_b_end_x;
      crd_in[7] = req_b_end_y;
   end

   always_ff @(posedge clock) begin
      if (en[0]) crd_ff[0] <= crd_in;
      for (int k = 1; k < KQ; k++) begin
         if (en[k]) crd_ff[k] <= crd_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: line differences, coordinate products, collinear tests
   // ---------------------------------------------------------------------
   logic signed [DW-1:0]  dif_in  [0:3];
   logic signed [PW-1:0]  cp_in   [0:3];
   logic signed [DPW-1:0] pr0_in  [0:3];
   logic signed [DPW-1:0] pr1_in  [0:3];
   logic                  box_in  [0:3];
   logic signed [DW-1:0]  dif_ff  [0:3];
   logic signed [PW-1:0]  cp_ff   [0:3];
   logic signed [DPW-1:0] pr0_ff  [0:3];
   logic signed [DPW-1:0] pr1_ff  [0:3];
   logic                  box_ff  [0:3];

   always_comb begin
      logic signed [DW-1:0] e0, e1, e2, e3;
      crd_type px, py, qx, qy, rx, ry;
      int sb, pi;
      // a1, b1, a2, b2
      dif_in[0] = DW'(crd_in[1]) - DW'(crd_in[3]);
      dif_in[1] = DW'(crd_in[2]) - DW'(crd_in[0]);
      dif_in[2] = DW'(crd_in[5]) - DW'(crd_in[7]);
      dif_in[3] = DW'(crd_in[6]) - DW'(crd_in[4]);
      cp_in[0]  = PW'(crd_in[1]) * PW'(crd_in[2]);
      cp_in[1]  = PW'(crd_in[0]) * PW'(crd_in[3]);
      cp_in[2]  = PW'(crd_in[5]) * PW'(crd_in[6]);
      cp_in[3]  = PW'(crd_in[4]) * PW'(crd_in[7]);
      // Endpoints of one segment against the other segment
      for (int t = 0; t < 4; t++) begin
         sb = (t < 2) ? 0 : 4;
         pi = (t < 2) ? 4 + 2*t : 2*(t-2);
         px = crd_in[sb];
         py = crd_in[sb+1];
         qx = crd_in[sb+2];
         qy = crd_in[sb+3];
         rx = crd_in[pi];
         ry = crd_in[pi+1];
         e0 = DW'(qx) - DW'(px);
         e1 = DW'(ry) - DW'(py);
         e2 = DW'(rx) - DW'(px);
         e3 = DW'(qy) - DW'(py);
         pr0_in[t] = DPW'(e0) * DPW'(e1);
         pr1_in[t] = DPW'(e2) * DPW'(e3);
         box_in[t] = (rx >= ((px < qx) ? px : qx)) && (rx <= ((px < qx) ? qx : px)) &&
                     (ry >= ((py < qy) ? py : qy)) && (ry <= ((py < qy) ? qy : py));
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dif_ff <= dif_in;
         cp_ff  <= cp_in;
         pr0_ff <= pr0_in;
         pr1_ff <= pr1_in;
         box_ff <= box_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: line constants, determinant products, collinear verdict
   // ---------------------------------------------------------------------
   logic signed [CCW-1:0] c1_ff, c2_ff;
   logic signed [DPW-1:0] da_ff, db_ff;
   logic signed [DW-1:0]  dif1_ff [0:3];
   logic                  par_in;

   always_comb begin
      par_in = 1'b0;
      for (int t = 0; t < 4; t++) begin
         par_in = par_in || (box_ff[t] && (pr0_ff[t] == pr1_ff[t]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c1_ff     <= CCW'(cp_ff[0]) - CCW'(cp_ff[1]);
         c2_ff     <= CCW'(cp_ff[2]) - CCW'(cp_ff[3]);
         da_ff     <= DPW'(dif_ff[0]) * DPW'(dif_ff[3]);
         db_ff     <= DPW'(dif_ff[2]) * DPW'(dif_ff[1]);
         dif1_ff   <= dif_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: determinant, split partial products of the numerators
   // ---------------------------------------------------------------------
   logic signed [DETW-1:0] det2_ff;
   logic signed [DPW-1:0]  pp_ff [0:7];
   logic signed [DPW-1:0]  pp_in [0:7];

   always_comb begin
      logic signed [DW-1:0] ch1, cl1, ch2, cl2;
      ch1 = c1_ff[CCW-1:CW];
      cl1 = $signed({1'b0, c1_ff[CW-1:0]});
      ch2 = c2_ff[CCW-1:CW];
      cl2 = $signed({1'b0, c2_ff[CW-1:0]});
      pp_in[0] = DPW'(ch1) * DPW'(dif1_ff[3]);
      pp_in[1] = DPW'(cl1) * DPW'(dif1_ff[3]);
      pp_in[2] = DPW'(ch2) * DPW'(dif1_ff[1]);
      pp_in[3] = DPW'(cl2) * DPW'(dif1_ff[1]);
      pp_in[4] = DPW'(ch2) * DPW'(dif1_ff[0]);
      pp_in[5] = DPW'(cl2) * DPW'(dif1_ff[0]);
      pp_in[6] = DPW'(ch1) * DPW'(dif1_ff[2]);
      pp_in[7] = DPW'(cl1) * DPW'(dif1_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         det2_ff  <= DETW'(da_ff) - DETW'(db_ff);
         pp_ff    <= pp_in;
      end
   end

   // Advance the collinear and zero-determinant flags with the item
   always_ff @(posedge clock) begin
      if (en[1]) par_ff[1] <= par_in;
      for (int k = 2; k <= KQ; k++) begin
         if (en[k]) par_ff[k] <= par_ff[k-1];
      end
      if (en[2]) dz_ff[2] <= (da_ff == db_ff);
      for (int k = 3; k <= KQ; k++) begin
         if (en[k]) dz_ff[k] <= dz_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: assemble full numerator products
   // ---------------------------------------------------------------------
   logic signed [DETW-1:0] det3_ff;
   logic signed [NW-1:0]   pf_ff [0:3];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         det3_ff <= det2_ff;
         for (int i = 0; i < 4; i++) begin
            pf_ff[i] <= (NW'(pp_ff[2*i]) <<< CW) + NW'(pp_ff[2*i+1]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: numerators
   // ---------------------------------------------------------------------
   logic signed [DETW-1:0] det4_ff;
   logic signed [NW-1:0]   nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         det4_ff <= det3_ff;
         nx_ff   <= pf_ff[0] - pf_ff[1];
         ny_ff   <= pf_ff[2] - pf_ff[3];
      end
   end

   // ---------------------------------------------------------------------
   // Dividers
   // ---------------------------------------------------------------------
   logic signed [QSW-1:0] qx_div, qy_div;

   sgi_div #(.COORD_BITS(COORD_BITS)) u_div_x (
      .clock (clock),
      .adv   (en[KQ-1:KDIV]),
      .num   (nx_ff),
      .den   (det4_ff),
      .quo   (qx_div)
   );

   sgi_div #(.COORD_BITS(COORD_BITS)) u_div_y (
      .clock (clock),
      .adv   (en[KQ-1:KDIV]),
      .num   (ny_ff),
      .den   (det4_ff),
      .quo   (qy_div)
   );

   // ---------------------------------------------------------------------
   // Point on both segments: bounding boxes and orientation products
   // ---------------------------------------------------------------------
   logic signed [XPW-1:0] sp0_in [0:1];
   logic signed [XPW-1:0] sp1_in [0:1];
   logic                  sb_in  [0:1];
   logic signed [XPW-1:0] sp0_ff [0:1];
   logic signed [XPW-1:0] sp1_ff [0:1];
   logic                  sb_ff  [0:1];
   logic signed [QSW-1:0] qx_ff, qy_ff;

   always_comb begin
      logic signed [DW-1:0]  ex, ey;
      logic signed [OW-1:0]  ox, oy;
      logic signed [QSW-1:0] xlo, xhi, ylo, yhi;
      crd_type px, py, rx, ry;
      for (int s = 0; s < 2; s++) begin
         px  = crd_ff[KQ-1][4*s];
         py  = crd_ff[KQ-1][4*s+1];
         rx  = crd_ff[KQ-1][4*s+2];
         ry  = crd_ff[KQ-1][4*s+3];
         ex  = DW'(rx) - DW'(px);
         ey  = DW'(ry) - DW'(py);
         ox  = OW'(qx_div) - OW'(px);
         oy  = OW'(qy_div) - OW'(py);
         sp0_in[s] = XPW'(ex) * XPW'(oy);
         sp1_in[s] = XPW'(ox) * XPW'(ey);
         xlo = QSW'((px < rx) ? px : rx);
         xhi = QSW'((px < rx) ? rx : px);
         ylo = QSW'((py < ry) ? py : ry);
         yhi = QSW'((py < ry) ? ry : py);
         sb_in[s] = (qx_div >= xlo) && (qx_div <= xhi) &&
                    (qy_div >= ylo) && (qy_div <= yhi);
      end
   end

   always_ff @(posedge clock) begin
      if (en[KQ]) begin
         sp0_ff <= sp0_in;
         sp1_ff <= sp1_in;
         sb_ff  <= sb_in;
         qx_ff  <= qx_div;
         qy_ff  <= qy_div;
      end
   end

   // ---------------------------------------------------------------------
   // Last stage: classify and hold the result
   // ---------------------------------------------------------------------
   outcome_type          outcome_ff, outcome_in;
   logic signed [CW-1:0] cross_x_ff, cross_x_in;
   logic signed [CW-1:0] cross_y_ff, cross_y_in;
   logic                 on_both;

   always_comb begin
      on_both    = sb_ff[0] && (sp0_ff[0] == sp1_ff[0]) &&
                   sb_ff[1] && (sp0_ff[1] == sp1_ff[1]);
      outcome_in = OUT_NONE;
      cross_x_in = '0;
      cross_y_in = '0;
      if (dz_ff[KQ]) begin
         if (par_ff[KQ]) outcome_in = OUT_SEGMENT;
      end else if (on_both) begin
         outcome_in = OUT_POINT;
         cross_x_in = qx_ff[CW-1:0];
         cross_y_in = qy_ff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[KL]) begin
         outcome_ff <= outcome_in;
         cross_x_ff <= cross_x_in;
         cross_y_ff <= cross_y_in;
      end
   end

   assign rsp_valid   = v_ff[KL];
   assign rsp_outcome = outcome_ff;
   assign rsp_cross_x = cross_x_ff;
   assign rsp_cross_y = cross_y_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("input stalled while output is free");

   a_point_only_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_outcome != OUT_POINT)) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("crossing coordinates set without a single point");

   a_last_advance: assert property (@(posedge clock) disable iff (reset)
      (v_ff[KL-1] && !rsp_stall) |=> rsp_valid)
      else $error("item lost entering the output stage");

   a_first_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && !en[0]) |=> v_ff[0])
      else $error("stalled first stage dropped its item");

endmodule

// ===== tb/sv/tb_segment_intersection_unit.sv =====
// ============================================================================
// Segment intersection unit testbench
// Sends segment pairs and compares each result against a predictor that
// works out the outcome and crossing point in wide integer arithmetic.
// ============================================================================
module tb_segment_intersection_unit import sgi_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int LIMIT = 400000;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct packed {
      coord_type ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   } pair_type;
   typedef struct packed {
      outcome_type outcome;
      coord_type   cx, cy;
   } meet_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   pair_type req = '0;
   logic req_stall, rsp_valid;
   logic [1:0] rsp_outcome;
   coord_type rsp_cross_x, rsp_cross_y;

   meet_type expected_meets[$];
   int errors = 0;
   int cycles = 0;
   bit idle_on = 1;

   segment_intersection_unit #(.COORD_BITS(CB)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_start_x(req.ax1), .req_a_start_y(req.ay1),
      .req_a_end_x(req.ax2), .req_a_end_y(req.ay2),
      .req_b_start_x(req.bx1), .req_b_start_y(req.by1),
      .req_b_end_x(req.bx2), .req_b_end_y(req.by2),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome), .rsp_cross_x(rsp_cross_x),
      .rsp_cross_y(rsp_cross_y)
   );

   always #4 clock = ~clock;

   // End the run at the cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit lies_on(longint ax, longint ay, longint bx, longint by,
                                  longint px, longint py);
      longint xlo, xhi, ylo, yhi;
      xlo = ax < bx ? ax : bx;
      xhi = ax < bx ? bx : ax;
      ylo = ay < by ? ay : by;
      yhi = ay < by ? by : ay;
      if (px < xlo || px > xhi || py < ylo || py > yhi) return 1'b0;
      return (bx - ax) * (py - ay) - (px - ax) * (by - ay) == 0;
   endfunction

   // Truncating quotient, saturated well beyond the coordinate range
   function automatic longint clamp_quot(logic signed [127:0] n, longint d);
      logic signed [127:0] q, lim;
      lim = 128'sd1 <<< (CB + 2);
      q = n / 128'(signed'(d));
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      return longint'(q);
   endfunction

   function automatic meet_type predict_meet(pair_type p);
      longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      longint a1, b1, c1, a2, b2, c2, det, qx, qy;
      logic signed [127:0] nx, ny;
      meet_type m;
      ax1 = p.ax1; ay1 = p.ay1; ax2 = p.ax2; ay2 = p.ay2;
      bx1 = p.bx1; by1 = p.by1; bx2 = p.bx2; by2 = p.by2;
      a1 = ay1 - ay2; b1 = ax2 - ax1; c1 = ay1 * ax2 - ax1 * ay2;
      a2 = by1 - by2; b2 = bx2 - bx1; c2 = by1 * bx2 - bx1 * by2;
      det = a1 * b2 - a2 * b1;
      m = '{OUT_NONE, '0, '0};
      if (det == 0) begin
         if (lies_on(ax1, ay1, ax2, ay2, bx1, by1) ||
             lies_on(ax1, ay1, ax2, ay2, bx2, by2) ||
             lies_on(bx1, by1, bx2, by2, ax1, ay1) ||
             lies_on(bx1, by1, bx2, by2, ax2, ay2))
            m.outcome = OUT_SEGMENT;
      end else begin
         nx = 128'(signed'(c1)) * b2 - 128'(signed'(c2)) * b1;
         ny = 128'(signed'(a1)) * c2 - 128'(signed'(a2)) * c1;
         qx = clamp_quot(nx, det);
         qy = clamp_quot(ny, det);
         if (lies_on(ax1, ay1, ax2, ay2, qx, qy) &&
             lies_on(bx1, by1, bx2, by2, qx, qy)) begin
            m.outcome = OUT_POINT;
            m.cx = coord_type'(qx);
            m.cy = coord_type'(qy);
         end
      end
      return m;
   endfunction

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      meet_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_meets.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            e = expected_meets.pop_front();
            if (rsp_outcome !== e.outcome) begin
               $error("outcome exp %0d got %0d", e.outcome, rsp_outcome);
               errors++;
            end
            if (rsp_cross_x !== e.cx) begin
               $error("cross_x exp %0d got %0d", e.cx, rsp_cross_x);
               errors++;
            end
            if (rsp_cross_y !== e.cy) begin
               $error("cross_y exp %0d got %0d", e.cy, rsp_cross_y);
               errors++;
            end
         end
      end
   end

   // Stall the result side in random bursts while idle_on is set
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   // Send one pair; valid stays high into the next send when no gap follows
   task automatic send_pair(pair_type p);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req <= p;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_meets = {expected_meets, predict_meet(p)};
   endtask

   task automatic drain_all();
      req_valid <= 0;
      @(posedge clock);
      while (expected_meets.size() != 0) @(posedge clock);
   endtask

   function automatic coord_type rnd_coord();
      case ($urandom_range(0, 3))
         0: return coord_type'($urandom_range(0, 65535));
         1: return coord_type'($urandom_range(0, 40) - 20);
         2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return coord_type'($urandom_range(0, 2000) - 1000);
      endcase
   endfunction

   function automatic pair_type rnd_pair();
      pair_type p;
      int k, t, sx, sy;
      p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
           rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
      case ($urandom_range(0, 4))
         // collinear: B on the line of A
         0: begin
            sx = int'($urandom_range(0, 20)) - 10; sy = int'($urandom_range(0, 20)) - 10;
            p.ax1 = coord_type'($urandom_range(0, 200) - 100);
            p.ay1 = coord_type'($urandom_range(0, 200) - 100);
            k = int'($urandom_range(0, 10)) - 3; t = int'($urandom_range(0, 10)) - 3;
            p.ax2 = coord_type'(p.ax1 + 4 * sx); p.ay2 = coord_type'(p.ay1 + 4 * sy);
            p.bx1 = coord_type'(p.ax1 + k * sx); p.by1 = coord_type'(p.ay1 + k * sy);
            p.bx2 = coord_type'(p.ax1 + t * sx); p.by2 = coord_type'(p.ay1 + t * sy);
         end
         // crossing through a lattice point
         1: begin
            p.ax1 = coord_type'($urandom_range(0, 200) - 100);
            p.ay1 = coord_type'($urandom_range(0, 200) - 100);
            p.ax2 = -p.ax1; p.ay2 = -p.ay1;
            p.bx1 = coord_type'($urandom_range(0, 200) - 100);
            p.by1 = coord_type'($urandom_range(0, 200) - 100);
            p.bx2 = -p.bx1; p.by2 = -p.by1;
         end
         // degenerate A
         2: begin
            p.ax2 = p.ax1; p.ay2 = p.ay1;
         end
         // small random
         3: p = {8{coord_type'($urandom_range(0, 16) - 8)}} ^
                {coord_type'($urandom_range(0, 15)), coord_type'($urandom_range(0, 15)),
                 coord_type'($urandom_range(0, 15)), coord_type'($urandom_range(0, 15)),
                 coord_type'($urandom_range(0, 15)), coord_type'($urandom_range(0, 15)),
                 coord_type'($urandom_range(0, 15)), coord_type'($urandom_range(0, 15))};
         default: ;
      endcase
      return p;
   endfunction

   task automatic test_directed();
      send_pair('{0, 0, 10, 10, 0, 10, 10, 0});          // crossing at a point
      send_pair('{0, 0, 3, 1, 0, 1, 3, 0});              // truncated point off line
      send_pair('{0, 0, 4, 0, 4, 0, 8, 0});              // collinear touch
      send_pair('{0, 0, 8, 0, 2, 0, 5, 0});              // collinear overlap
      send_pair('{0, 0, 4, 0, 5, 0, 8, 0});              // collinear apart
      send_pair('{0, 0, 4, 0, 0, 1, 4, 1});              // parallel
      send_pair('{2, 2, 2, 2, 0, 0, 4, 4});              // degenerate on other
      send_pair('{2, 3, 2, 3, 0, 0, 4, 4});              // degenerate off
      send_pair('{3, 3, 3, 3, 3, 3, 3, 3});              // two equal points
      send_pair('{0, 0, 1, 1, 0, 1, 1, 2});              // parallel near
      send_pair('{0, 0, 1, 0, 0, 1, 1, 2});              // far crossing
      send_pair('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
      send_pair('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000});
      send_pair('{16'sh8000, 0, 16'sh7fff, 1, 0, 16'sh8000, 1, 16'sh7fff});
      send_pair('{16'shffff, 16'shffff, 16'shffff, 16'shffff,
                  16'shffff, 16'shffff, 16'shffff, 16'shffff});
      send_pair('{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                  16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555});
      send_pair('{-5, -5, 5, 5, -5, 5, 5, -5});
      send_pair('{0, 0, 7, 3, 7, 0, 0, 3});
   endtask

   task automatic test_random(int count);
      repeat (count) send_pair(rnd_pair());
   endtask

   task automatic test_no_idle(int count);
      idle_on = 0;
      repeat (count) send_pair(rnd_pair());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      drain_all();
      test_random(700);
      test_no_idle(150);
      drain_all();
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_meets.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
